/* hw/rtl/three_level_priority_run_queue_unit_assert.svh */
// Assertion macros used by the run queue top level.
`ifndef THREE_LEVEL_PRIORITY_RUN_QUEUE_UNIT_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_RUN_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TLPRQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TLPRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tlprq_pkg.sv */
// Package with the shared types, codes and level selection of the run queue.
`default_nettype none

package tlprq_pkg;

    localparam int NUM_LEVELS = 3;
    localparam int TAG_W      = 6;

    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [1:0]       t_level;
    typedef logic [1:0]       t_reason;

    // Priority levels.
    localparam t_level LVL_LOW  = 2'd0;
    localparam t_level LVL_MED  = 2'd1;
    localparam t_level LVL_HIGH = 2'd2;

    // Commands.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Reason codes carried with a push.
    localparam t_reason REASON_DEFAULT = 2'd0;
    localparam t_reason REASON_WAKE    = 2'd1;
    localparam t_reason REASON_SLICE   = 2'd2;

    // Pointer update request from the top level to the pointer file.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_level push_level;
    } t_ptr_cmd;

    // Occupancy status reported by the pointer file.
    typedef struct packed {
        logic [NUM_LEVELS-1:0] nonempty;
        logic [NUM_LEVELS-1:0] full;
        logic                  any;
        t_level                pop_level;
    } t_ptr_status;

    // Level a push goes to: saturate to high, then adjust by reason in dynamic mode.
    function automatic t_level pick_level(t_level prio, t_reason why, logic dyn);
        t_level lvl;
        lvl = (prio > LVL_HIGH) ? LVL_HIGH : prio;
        if (dyn) begin
            case (why)
                REASON_WAKE:  lvl = LVL_HIGH;
                REASON_SLICE: begin
                    if (lvl != LVL_LOW) begin
                        lvl = lvl - t_level'(1);
                    end
                end
                default: ;
            endcase
        end
        return lvl;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/tlprq_in_if.sv */
// Command channel interface of the run queue.
`default_nettype none

interface tlprq_in_if import tlprq_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    command;
    t_tag    process_tag;
    t_level  priority_in;
    t_reason reason;

    modport source (output valid, command, process_tag, priority_in, reason, input ready);
    modport sink   (input valid, command, process_tag, priority_in, reason, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tlprq_out_if.sv */
// Result channel interface of the run queue.
`default_nettype none

interface tlprq_out_if import tlprq_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   tag_valid;
    t_tag   process_tag_out;
    t_level priority_out;
    logic   queue_empty;
    logic   overflow;

    modport source (output valid, tag_valid, process_tag_out, priority_out, queue_empty,
                    overflow, input ready);
    modport sink   (input valid, tag_valid, process_tag_out, priority_out, queue_empty,
                    overflow, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tlprq_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tlprq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, enabled by i_re.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/tlprq_ptrs.sv */
// Head, tail and count registers of the three levels, and slot address generation.
`default_nettype none

module tlprq_ptrs import tlprq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire t_ptr_cmd                                 i_cmd,
    output      t_ptr_status                              o_status,
    output      logic [$clog2(NUM_LEVELS*QUEUE_DEPTH)-1:0] o_wr_addr,
    output      logic [$clog2(NUM_LEVELS*QUEUE_DEPTH)-1:0] o_rd_addr
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_LEVELS * QUEUE_DEPTH);

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] BASE_MED  = ADDR_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] BASE_HIGH = ADDR_W'(2 * QUEUE_DEPTH);

    logic [PTR_W-1:0] r_head  [NUM_LEVELS];
    logic [PTR_W-1:0] r_tail  [NUM_LEVELS];
    logic [CNT_W-1:0] r_count [NUM_LEVELS];

    t_level pop_level;

    function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(t_level lvl, logic [PTR_W-1:0] p);
        logic [ADDR_W-1:0] base;
        unique case (lvl)
            LVL_LOW:  base = '0;
            LVL_MED:  base = BASE_MED;
            default:  base = BASE_HIGH;
        endcase
        return base + ADDR_W'(p);
    endfunction

    // Occupancy flags and the highest level that holds a tag.
    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            o_status.nonempty[l] = (r_count[l] != '0);
            o_status.full[l]     = (r_count[l] == CNT_FULL);
        end
        if (o_status.nonempty[LVL_HIGH]) begin
            pop_level = LVL_HIGH;
        end else if (o_status.nonempty[LVL_MED]) begin
            pop_level = LVL_MED;
        end else begin
            pop_level = LVL_LOW;
        end
        o_status.pop_level = pop_level;
        o_status.any       = |o_status.nonempty;
    end

    // Slot addresses: tail of the push level and head of the pop level.
    assign o_wr_addr = slot_addr(i_cmd.push_level, r_tail[i_cmd.push_level]);
    assign o_rd_addr = slot_addr(pop_level, r_head[pop_level]);

    // Pointer and count update; a push and a pop never come in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else if (i_cmd.push) begin
            r_tail[i_cmd.push_level]  <= next_ptr(r_tail[i_cmd.push_level]);
            r_count[i_cmd.push_level] <= r_count[i_cmd.push_level] + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_head[pop_level]  <= next_ptr(r_head[pop_level]);
            r_count[pop_level] <= r_count[pop_level] - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/three_level_priority_run_queue_unit.sv */
// Top level of the three-level priority run queue.
//
// The command channel i_in carries one beat per push or pop; the result
// channel o_out returns exactly one beat for each command, in order.
// A push is decided in the cycle it is accepted: the tag is written into
// the slot memory at the tail of its level, unless the level is full and
// overflow is flagged, and the result beat is valid on the next cycle.
// Pushes are taken at one per cycle while the receiver takes each result.
// A pop reads the head slot of the highest non-empty level from the slot
// memory through its registered read port; no new command is taken while
// the block waits in ST_READ for the tag, which then goes to the output
// register. A pop that finds every level empty answers at once, like a push.
// The result sits in an output register; a new command is accepted while
// the previous result is taken in the same cycle, and i_in.ready falls
// while a result is held by a stalling receiver.
// Synchronous reset empties all three levels and clears dynamic mode; the
// slot memory itself is not cleared. i_cfg_we writes dynamic mode and
// should only be used while no command is in flight.
`default_nettype none
`include "three_level_priority_run_queue_unit_assert.svh"

module three_level_priority_run_queue_unit import tlprq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_wdata,
    tlprq_in_if.sink    i_in,
    tlprq_out_if.source o_out
);

    localparam int ADDR_W = $clog2(NUM_LEVELS * QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    t_state r_state, n_state;
    t_level r_pop_level, n_pop_level;
    logic   r_dyn_mode;

    logic   r_out_valid, n_out_valid;
    logic   r_tag_valid, n_tag_valid;
    t_tag   r_tag,       n_tag;
    t_level r_prio,      n_prio;
    logic   r_empty,     n_empty;
    logic   r_ovf,       n_ovf;

    t_ptr_cmd          ptr_cmd;
    t_ptr_status       ptr_status;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    t_tag              rd_data;

    logic   in_ready;
    logic   accept;
    logic   is_push;
    t_level push_level;
    logic   push_full;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_dyn_mode <= i_cfg_wdata;
        end
    end

    // Command decode and handshake.
    assign in_ready   = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && in_ready;
    assign is_push    = (i_in.command == CMD_PUSH);
    assign push_level = pick_level(i_in.priority_in, i_in.reason, r_dyn_mode);
    assign push_full  = ptr_status.full[push_level];

    assign ptr_cmd.push       = accept && is_push && !push_full;
    assign ptr_cmd.pop        = accept && !is_push && ptr_status.any;
    assign ptr_cmd.push_level = push_level;

    tlprq_ptrs #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ptrs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (ptr_cmd),
        .o_status  (ptr_status),
        .o_wr_addr (wr_addr),
        .o_rd_addr (rd_addr)
    );

    tlprq_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_LEVELS * QUEUE_DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ptr_cmd.push),
        .i_waddr (wr_addr),
        .i_wdata (i_in.process_tag),
        .i_re    (ptr_cmd.pop),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Sequencer and result register next values.
    always_comb begin
        n_state     = r_state;
        n_pop_level = r_pop_level;
        n_out_valid = r_out_valid && !o_out.ready;
        n_tag_valid = r_tag_valid;
        n_tag       = r_tag;
        n_prio      = r_prio;
        n_empty     = r_empty;
        n_ovf       = r_ovf;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (is_push) begin
                        n_out_valid = 1'b1;
                        n_tag_valid = 1'b0;
                        n_tag       = i_in.process_tag;
                        n_prio      = push_level;
                        n_empty     = 1'b0;
                        n_ovf       = push_full;
                    end else if (ptr_status.any) begin
                        n_state     = ST_READ;
                        n_pop_level = ptr_status.pop_level;
                    end else begin
                        n_out_valid = 1'b1;
                        n_tag_valid = 1'b0;
                        n_tag       = '0;
                        n_prio      = LVL_LOW;
                        n_empty     = 1'b1;
                        n_ovf       = 1'b0;
                    end
                end
            end
            ST_READ: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_tag_valid = 1'b1;
                n_tag       = rd_data;
                n_prio      = r_pop_level;
                n_empty     = 1'b0;
                n_ovf       = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pop_level <= n_pop_level;
        r_tag_valid <= n_tag_valid;
        r_tag       <= n_tag;
        r_prio      <= n_prio;
        r_empty     <= n_empty;
        r_ovf       <= n_ovf;
    end

    // Channel outputs.
    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.tag_valid       = r_tag_valid;
    assign o_out.process_tag_out = r_tag;
    assign o_out.priority_out    = r_prio;
    assign o_out.queue_empty     = r_empty;
    assign o_out.overflow        = r_ovf;

    // The read state of a pop is always followed by the idle state.
    `TLPRQ_ASSERT_NEXT(a_read_one_cycle, i_clk, i_rst_n, r_state == ST_READ, r_state == ST_IDLE, "pop read stayed longer than one cycle")
    // A pop that found a tag always enters the read cycle.
    `TLPRQ_ASSERT_NEXT(a_pop_to_read, i_clk, i_rst_n, ptr_cmd.pop, r_state == ST_READ, "pop with a tag did not start a memory read")
    // The result register is free while the read data is on its way.
    `TLPRQ_ASSERT_NOW(a_out_free_on_read, i_clk, i_rst_n, r_state == ST_READ, !r_out_valid, "pop result would overwrite a pending result")
    // A result never reports both a returned tag and an empty queue.
    `TLPRQ_ASSERT_NOW(a_result_flags, i_clk, i_rst_n, r_out_valid, !(r_tag_valid && r_empty), "result flags tag valid and queue empty together")

endmodule

`default_nettype wire
